@@ sv/ile_pkg.sv @@
package ile_pkg;

    // list sizing
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 16;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    localparam int OCNT_W   = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_GET  = 3'd0;
    localparam logic [OP_W-1:0] OP_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL  = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_cell_ctrl;

    // count as shown on the result beat, all of its bits
    function automatic logic [OCNT_W-1:0] to_out_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCNT_W-1:0] ext;
        ext = {{OCNT_W{1'b0}}, cnt};
        return ext[OCNT_W-1:0];
    endfunction

endpackage

@@ sv/ile_if.sv @@
// command channel
interface ile_in_if;
    logic                       valid;
    logic                       ready;
    logic [ile_pkg::OP_W-1:0]   operation;
    logic [ile_pkg::POS_W-1:0]  position;
    logic signed [ile_pkg::DATA_W-1:0] item_value;

    modport source (output valid, output operation, output position, output item_value,
                    input ready);
    modport sink   (input valid, input operation, input position, input item_value,
                    output ready);
endinterface

// result channel
interface ile_out_if;
    logic                       valid;
    logic                       ready;
    logic signed [ile_pkg::DATA_W-1:0] read_value;
    logic [ile_pkg::ST_W-1:0]   status;
    logic [ile_pkg::OCNT_W-1:0] entry_count;

    modport source (output valid, output read_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input entry_count,
                    output ready);
endinterface

@@ sv/ile_cell.sv @@
module ile_cell (
    input  logic                       i_clk,
    input  ile_pkg::t_cell_ctrl        i_ctrl,
    input  logic [ile_pkg::IDX_W-1:0]  i_index,
    input  logic [ile_pkg::DATA_W-1:0] i_prev,
    input  logic [ile_pkg::DATA_W-1:0] i_next,
    output logic [ile_pkg::DATA_W-1:0] o_entry,
    output logic [ile_pkg::DATA_W-1:0] o_read
);
    import ile_pkg::*;

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    logic [POS_W-1:0]  w_idx;

    assign w_idx = POS_W'(i_index);

    // shift toward the tail on insert, toward the head on delete
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (w_idx > i_ctrl.pos) begin
                n_entry = i_prev;
            end else if (w_idx == i_ctrl.pos) begin
                n_entry = i_ctrl.value;
            end
        end else if (i_ctrl.del) begin
            if (w_idx >= i_ctrl.pos) begin
                n_entry = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // drive the shared read bus only when addressed
    assign o_read  = (w_idx == i_ctrl.pos) ? r_entry : '0;
    assign o_entry = r_entry;

endmodule

@@ sv/indexed_list_engine_unit.sv @@
// channel | dir | beat contents
// --------+-----+------------------------------------------
// i_in    | in  | operation, position, item_value
// o_out   | out | read_value, status, entry_count
//
// one command per cycle while results are drained: every cell shifts in parallel in the accept cycle and
// the result beat is registered, so it appears the cycle after acceptance.
// throughput is set by the single output register: a new command is taken
// whenever that register is empty or is being drained in the same cycle.
// synchronous active-low reset clears the count and the output valid; cell
// contents are left as they are and entries past the count are never read.
module indexed_list_engine_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ile_in_if.sink    i_in,
    ile_out_if.source o_out
);
    import ile_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_value;
    logic [ST_W-1:0]   r_status;
    logic [DATA_W-1:0] n_read_value;
    logic [ST_W-1:0]   n_status;

    logic              w_accept;
    logic [POS_W-1:0]  w_cnt16;
    logic              w_full;
    logic              w_do_ins;
    logic              w_do_del;
    logic              w_get_hit;
    t_cell_ctrl        w_ctrl;
    logic [DATA_W-1:0] w_entry [CAPACITY];
    logic [DATA_W-1:0] w_read  [CAPACITY];
    logic [DATA_W-1:0] w_read_any;

    // handshake
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_cnt16 = POS_W'(r_count);
    assign w_full  = (r_count >= CNT_W'(CAPACITY));

    // command decode
    always_comb begin
        w_do_ins     = 1'b0;
        w_do_del     = 1'b0;
        w_get_hit    = 1'b0;
        w_ctrl.pos   = i_in.position;
        w_ctrl.value = i_in.item_value;
        n_status     = ST_DONE;
        unique case (i_in.operation) inside
            OP_GET: begin
                if (i_in.position < w_cnt16) begin
                    w_get_hit = 1'b1;
                end else begin
                    n_status = ST_BAD_POS;
                end
            end
            OP_HEAD, OP_TAIL, OP_AT: begin
                if (i_in.operation == OP_HEAD) begin
                    w_ctrl.pos = '0;
                end else if (i_in.operation == OP_TAIL) begin
                    w_ctrl.pos = w_cnt16;
                end
                if (w_ctrl.pos > w_cnt16) begin
                    n_status = ST_BAD_POS;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            OP_DEL: begin
                if (i_in.position >= w_cnt16) begin
                    n_status = ST_BAD_POS;
                end else begin
                    w_do_del = 1'b1;
                end
            end
            default: begin
            end
        endcase
        w_ctrl.ins = w_accept && w_do_ins;
        w_ctrl.del = w_accept && w_do_del;
    end

    // get result from the read bus, all ones on a miss
    always_comb begin
        n_read_value = '0;
        if (i_in.operation == OP_GET) begin
            n_read_value = w_get_hit ? w_read_any : '1;
        end
    end

    // count update
    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // row of cells linked to their neighbors; the first takes the insert value as prev, the last its own entry as next
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = w_ctrl.value;
        end else begin : g_mid_prev
            assign w_prev = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_mid_next
            assign w_next = w_entry[g+1];
        end
        ile_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_index (IDX_W'(g)),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_entry (w_entry[g]),
            .o_read  (w_read[g])
        );
    end

    // wired-or read bus, at most one cell drives nonzero
    always_comb begin
        w_read_any = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_read_any = w_read_any | w_read[k];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.read_value  = r_read_value;
    assign o_out.status      = r_status;
    assign o_out.entry_count = to_out_count(r_count);

endmodule
